@@ design/lbbs_pkg.sv @@
// Package: shared types and constants for the LED blink and beep sequencer.
`timescale 1ns / 1ps

package lbbs_pkg;

   typedef enum logic [1:0] {
      CSR_LED_COLOR    = 2'd0,
      CSR_LED_MODE     = 2'd1,
      CSR_LED_LEVEL    = 2'd2,
      CSR_SOUND_ENABLE = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      COLOR_OFF    = 3'd0,
      COLOR_RED    = 3'd1,
      COLOR_GREEN  = 3'd2,
      COLOR_ORANGE = 3'd3,
      COLOR_BLUE   = 3'd4,
      COLOR_YELLOW = 3'd5,
      COLOR_WHITE  = 3'd6,
      COLOR_NONE   = 3'd7
   } color_type;

   typedef enum logic [1:0] {
      MODE_SOLID = 2'd0,
      MODE_SLOW  = 2'd1,
      MODE_FAST  = 2'd2,
      MODE_ALT   = 2'd3
   } mode_type;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_BEEP = 1'b1;

   // Millisecond time is kept as a sub-100 count plus a hundreds digit.
   localparam logic [6:0] SUB_LAST  = 7'd99;
   localparam logic [3:0] HUND_LAST = 4'd9;
   localparam logic [3:0] HUND_SLOW = 4'd5;

   localparam logic [7:0]  LEVEL_RESET = 8'd40;
   localparam logic [15:0] FREQ_RESET  = 16'd2000;
   localparam logic [9:0]  DUTY_ON     = 10'd512;
   localparam logic [9:0]  DUTY_OFF    = 10'd0;

endpackage

@@ design/led_blink_and_beep_sequencer.sv @@
// Top level: LED blink and beep sequencer with registered result stage.
`timescale 1ns / 1ps

// Usage
//   req_*  : one transaction per millisecond tick (op 0) or beep request (op 1).
//   rsp_*  : one result transaction per request transaction: LED levels and
//            buzzer settings after that transaction has been applied.
//   csr_*  : register writes (index 0 color, 1 mode, 2 level, 3 sound enable);
//            csr_ready is always high, write only while the block is idle.
// A transaction accepted at one edge shows its result on rsp_* right after
// that edge. Throughput is one transaction per cycle while no result is stalled;
// the state update and result decode sit between the request handshake and
// the result register, and only a stalled result limits the rate.
// When the receiver stalls, the result register holds and req_stall rises in
// the same cycle, so no transaction is lost; the next one is taken in the
// cycle the held result drains.
// Synchronous reset clears time, countdown and tone, sets the frequency to
// 2000 Hz, LED level to 40 and sound enable to 1, and empties the result stage.
module led_blink_and_beep_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_tone_freq_hz,
   input  logic [15:0] req_beep_ms,
   input  logic [7:0]  req_beep_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_led_red,
   output logic [7:0]  rsp_led_green,
   output logic [7:0]  rsp_led_blue,
   output logic        rsp_tone_active,
   output logic [15:0] rsp_tone_freq_out,
   output logic [9:0]  rsp_tone_duty,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import lbbs_pkg::*;

   // configuration
   logic [2:0]  led_color_ff;
   logic [1:0]  led_mode_ff;
   logic [7:0]  led_level_ff;
   logic        sound_enable_ff;

   // sequencer state
   logic [6:0]  sub_ff,   sub_in;
   logic [3:0]  hund_ff,  hund_in;
   logic [15:0] wait_ff,  wait_in;
   logic [8:0]  trans_ff, trans_in;
   logic        tone_on_ff, tone_on_in;
   logic [15:0] freq_ff,  freq_in;
   logic [15:0] phase_ff, phase_in;

   // result register
   logic        rsp_valid_ff;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff, blue_in;

   logic        accept;
   logic [15:0] wait_dec;
   logic        blank;
   color_type   shown;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_color_ff    <= COLOR_OFF;
         led_mode_ff     <= MODE_SOLID;
         led_level_ff    <= LEVEL_RESET;
         sound_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_LED_COLOR:    led_color_ff    <= csr_wdata[2:0];
            CSR_LED_MODE:     led_mode_ff     <= csr_wdata[1:0];
            CSR_LED_LEVEL:    led_level_ff    <= csr_wdata;
            CSR_SOUND_ENABLE: sound_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // next sequencer state for the transaction at the request port
   always_comb begin
      sub_in     = sub_ff;
      hund_in    = hund_ff;
      wait_in    = wait_ff;
      trans_in   = trans_ff;
      tone_on_in = tone_on_ff;
      freq_in    = freq_ff;
      phase_in   = phase_ff;
      wait_dec   = (wait_ff != 16'd0) ? wait_ff - 16'd1 : 16'd0;
      if (req_op == OP_TICK) begin
         if (sub_ff == SUB_LAST) begin
            sub_in  = 7'd0;
            hund_in = (hund_ff == HUND_LAST) ? 4'd0 : hund_ff + 4'd1;
         end else begin
            sub_in = sub_ff + 7'd1;
         end
         if (trans_ff != 9'd0 && wait_dec == 16'd0) begin
            trans_in   = trans_ff - 9'd1;
            tone_on_in = !tone_on_ff;
            wait_in    = phase_ff;
         end else begin
            wait_in = wait_dec;
            if (trans_ff == 9'd0) tone_on_in = 1'b0;
         end
      end else if (req_beep_count != 8'd0 && sound_enable_ff) begin
         freq_in    = req_tone_freq_hz;
         phase_in   = req_beep_ms;
         wait_in    = req_beep_ms;
         trans_in   = {req_beep_count, 1'b0} - 9'd1;
         tone_on_in = 1'b1;
      end
   end

   // LED decode from the updated time
   always_comb begin
      case (mode_type'(led_mode_ff))
         MODE_SOLID: blank = 1'b0;
         MODE_FAST:  blank = hund_in[0];
         default:    blank = (hund_in >= HUND_SLOW);
      endcase
      shown    = blank ? COLOR_OFF : color_type'(led_color_ff);
      red_in   = 8'd0;
      green_in = 8'd0;
      blue_in  = 8'd0;
      case (shown)
         COLOR_RED:    red_in = led_level_ff;
         COLOR_GREEN:  green_in = led_level_ff;
         COLOR_ORANGE: begin
            red_in   = led_level_ff;
            green_in = {1'b0, led_level_ff[7:1]};
         end
         COLOR_BLUE:   blue_in = led_level_ff;
         COLOR_YELLOW: begin
            red_in   = led_level_ff;
            green_in = led_level_ff;
         end
         COLOR_WHITE: begin
            red_in   = led_level_ff;
            green_in = led_level_ff;
            blue_in  = led_level_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= 7'd0;
         hund_ff      <= 4'd0;
         wait_ff      <= 16'd0;
         trans_ff     <= 9'd0;
         tone_on_ff   <= 1'b0;
         freq_ff      <= FREQ_RESET;
         phase_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            sub_ff     <= sub_in;
            hund_ff    <= hund_in;
            wait_ff    <= wait_in;
            trans_ff   <= trans_in;
            tone_on_ff <= tone_on_in;
            freq_ff    <= freq_in;
            phase_ff   <= phase_in;
         end
         if (accept) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_led_red       = red_ff;
   assign rsp_led_green     = green_ff;
   assign rsp_led_blue      = blue_ff;
   assign rsp_tone_active   = tone_on_ff;
   assign rsp_tone_freq_out = freq_ff;
   assign rsp_tone_duty     = tone_on_ff ? DUTY_ON : DUTY_OFF;

`ifndef SYNTHESIS
   // time digits stay in range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (sub_ff <= SUB_LAST) && (hund_ff <= HUND_LAST))
      else $error("millisecond time out of range");

   // a tick with no transitions pending silences the tone
   a_tick_silence: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_TICK && trans_ff == 9'd0) |=> !tone_on_ff)
      else $error("tone left on with no transitions pending");

   // a stalled result holds its state, so no request is taken
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !accept)
      else $error("request accepted while result is stalled");
`endif

endmodule
